// ===== rtl/lccc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the low current charge cutoff block.
package lccc_pkg;

    localparam int DATA_W      = 16;
    localparam int SOC_W       = 7;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // Magnitude of (current - mean) needs 17 bits; one quotient bit per step.
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF_ENABLE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF_TICKS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF_CURRENT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_SOC    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_CELL_MV  = 3'd4;

    localparam logic [SOC_W-1:0] RELEASE_SOC_RESET = 7'd100;

    typedef struct packed {
        logic                     cutoff_enable;
        logic [DATA_W-1:0]        cutoff_ticks;
        logic signed [DATA_W-1:0] cutoff_current;
        logic [SOC_W-1:0]         release_soc;
        logic [DATA_W-1:0]        start_cell_mv;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_UPDATE,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic update;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/lccc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences evaluation, serial division and result push.
module lccc_ctrl import lccc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = sts.need_div ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                if (sts.div_last) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load_in   = s_axis_tvalid;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
            end
            S_PUSH: begin
                cmd.push = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/lccc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: input capture, cutoff state, serial signed divider and output register.
module lccc_datapath import lccc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  ctrl_cmd_t              cmd,
    output ctrl_sts_t              sts,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Captured transaction
    logic signed [DATA_W-1:0] lim_reg;
    logic signed [DATA_W-1:0] cur_reg;
    logic [SOC_W-1:0]         soc_reg;
    logic [DATA_W-1:0]        cell_reg;
    logic                     bal_reg;

    // Cutoff state
    logic [DATA_W-1:0]        timer_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0]        count_reg;

    // Staged result
    logic signed [DATA_W-1:0] res_limit_reg;
    logic                     res_float_reg;

    // Divider
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W:0]      quo_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                     m_valid_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg;

    logic              timer_hit;
    logic [DATA_W-1:0] count_inc;
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   diff_mag;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W:0]   trial_sub;
    logic [DATA_W+1:0] quo_signed;
    logic [DATA_W+1:0] mean_sum;
    logic [DATA_W-1:0] new_mean;
    logic              start_ok;
    logic              mean_low;

    always_comb begin
        timer_hit = timer_reg >= cfg.cutoff_ticks;
        count_inc = (count_reg == {DATA_W{1'b1}}) ? count_reg : count_reg + 1'b1;
        diff      = {cur_reg[DATA_W-1], cur_reg} - {mean_reg[DATA_W-1], mean_reg};
        diff_mag  = diff[DATA_W] ? (~diff + 1'b1) : diff;
        trial     = {rem_reg, quo_reg[DATA_W]};
        fits      = trial >= {1'b0, count_reg};
        trial_sub = trial - {1'b0, count_reg};
        quo_signed = neg_reg ? (~{1'b0, quo_reg} + 1'b1) : {1'b0, quo_reg};
        mean_sum  = {{2{mean_reg[DATA_W-1]}}, mean_reg} + quo_signed;
        new_mean  = mean_sum[DATA_W-1:0];
        if (cfg.start_cell_mv != '0) begin
            start_ok = (cell_reg >= cfg.start_cell_mv) || (timer_reg != '0);
        end else begin
            start_ok = soc_reg >= cfg.release_soc;
        end
        mean_low = $signed(new_mean) < cfg.cutoff_current;
    end

    always_comb begin
        sts.need_div = !bal_reg && cfg.cutoff_enable && !timer_hit;
        sts.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
        sts.out_free = !m_valid_reg || m_axis_tready;
    end

    // Payload, staged result, divider and output data registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lim_reg  <= s_axis_tdata[15:0];
            cur_reg  <= s_axis_tdata[31:16];
            soc_reg  <= s_axis_tdata[38:32];
            cell_reg <= s_axis_tdata[54:39];
            bal_reg  <= s_axis_tdata[55];
        end
        if (cmd.eval) begin
            res_limit_reg <= lim_reg;
            res_float_reg <= 1'b0;
            if (!bal_reg && cfg.cutoff_enable && timer_hit) begin
                res_float_reg <= 1'b1;
                if (soc_reg >= cfg.release_soc) begin
                    res_limit_reg <= '0;
                end
            end
            rem_reg     <= '0;
            quo_reg     <= diff_mag;
            neg_reg     <= diff[DATA_W];
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg     <= {quo_reg[DATA_W-1:0], fits};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.push) begin
            m_data_reg <= {7'd0, timer_reg, mean_reg, res_float_reg, res_limit_reg};
        end
    end

    // Cutoff state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg   <= '0;
            mean_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.eval) begin
                if (bal_reg) begin
                    timer_reg <= '0;
                    mean_reg  <= '0;
                    count_reg <= '0;
                end else if (cfg.cutoff_enable) begin
                    if (timer_hit) begin
                        // release the cutoff once SoC drops
                        if (soc_reg < cfg.release_soc) begin
                            timer_reg <= '0;
                            mean_reg  <= '0;
                            count_reg <= '0;
                        end
                    end else begin
                        count_reg <= count_inc;
                    end
                end
            end
            if (cmd.update) begin
                if (mean_low && start_ok) begin
                    mean_reg  <= new_mean;
                    timer_reg <= timer_reg + 1'b1;
                end else begin
                    timer_reg <= '0;
                    mean_reg  <= '0;
                    count_reg <= '0;
                end
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== rtl/low_current_charge_cutoff_core.sv =====
`timescale 1ns / 1ps
// Top level of the low current charge cutoff block: config registers, controller, datapath.
//
// One transaction is one control tick. A tick that does not update the running
// mean (autobalance active, cutoff disabled, or timer already reached) goes from
// evaluation straight to the result push; a tick that updates the mean first runs
// the serial signed divider, which produces one quotient bit per cycle, and then
// the mean update. Results wait in an output register, so a tick may be accepted
// while the previous result is still pending; the block stalls only when a new
// result is ready and the output register is still full. Configuration writes
// are always accepted and must be issued while no tick is in flight.
module low_current_charge_cutoff_core import lccc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // limit_in[15:0], battery_current[31:16], soc_percent[38:32],
    // max_cell_mv[54:39], balancing[55]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // limit_out[15:0], float_request[16], mean_current[32:17],
    // tick_count[48:33], zero[55:49]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t      cfg_reg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff_enable  <= 1'b0;
            cfg_reg.cutoff_ticks   <= '0;
            cfg_reg.cutoff_current <= '0;
            cfg_reg.release_soc    <= RELEASE_SOC_RESET;
            cfg_reg.start_cell_mv  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_CUTOFF_ENABLE:  cfg_reg.cutoff_enable  <= cfg_data[0];
                REG_CUTOFF_TICKS:   cfg_reg.cutoff_ticks   <= cfg_data;
                REG_CUTOFF_CURRENT: cfg_reg.cutoff_current <= cfg_data;
                REG_RELEASE_SOC:    cfg_reg.release_soc    <= cfg_data[SOC_W-1:0];
                REG_START_CELL_MV:  cfg_reg.start_cell_mv  <= cfg_data;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    lccc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lccc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // One tick in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick is in flight");

    // Never overwrite a pending result
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result pushed over a pending transaction");

    // A new result appears only after a push
    a_valid_from_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(cmd.push))
        else $error("output valid raised without a push");

endmodule
